// File: sv/assert_macros.svh
// Assertion helpers for the design file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/tks_pkg.sv
package tks_pkg;

   localparam int NUM_FIELDS = 5;
   localparam int WORD_W     = 32;
   localparam int CFG_W      = 21;
   localparam int CSR_IDX_W  = 1;
   localparam int SAT_W      = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 1'd1;

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = 21'd262;
   localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 21'd32768;

   typedef struct packed {
      logic signed [WORD_W-1:0] delta_x;
      logic signed [WORD_W-1:0] delta_y;
      logic signed [WORD_W-1:0] delta_angle;
      logic signed [WORD_W-1:0] scale_x;
      logic signed [WORD_W-1:0] scale_y;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] smooth_x;
      logic signed [WORD_W-1:0] smooth_y;
      logic signed [WORD_W-1:0] smooth_angle;
      logic signed [WORD_W-1:0] smooth_scale_x;
      logic signed [WORD_W-1:0] smooth_scale_y;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CFG_W-1:0]     reg_data;
   } csr_word_type;

   typedef logic signed [WORD_W-1:0] field_arr_type [NUM_FIELDS];

   function automatic field_arr_type to_fields(input req_word_type w);
      field_arr_type f;
      f[0] = w.delta_x;
      f[1] = w.delta_y;
      f[2] = w.delta_angle;
      f[3] = w.scale_x;
      f[4] = w.scale_y;
      return f;
   endfunction

   function automatic rsp_word_type from_fields(input field_arr_type f);
      rsp_word_type w;
      w.smooth_x       = f[0];
      w.smooth_y       = f[1];
      w.smooth_angle   = f[2];
      w.smooth_scale_x = f[3];
      w.smooth_scale_y = f[4];
      return w;
   endfunction

   // Clamp a wide signed value to the 32 bit signed range.
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32'sh7FFF_FFFF);
      lo = -hi - SAT_W'(1);
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[WORD_W-1:0];
   endfunction

endpackage

// File: sv/tks_stream_if.sv
interface tks_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// File: sv/trajectory_kalman_smoother.sv
// Trajectory smoother for video stabilization: each input word carries one frame's motion
// (translation x and y, angle, scale x and y, signed with FRAC_BITS fraction bits); every
// channel keeps a saturating trajectory sum and a scalar Kalman estimate of it, and the result
// word gives delta + estimate - sum per channel, saturated. Channels run one after another
// through one shared restoring divider for the gain and one pair of shift-add multipliers,
// each retiring one bit per cycle. Each active channel (CHANNELS, capped at five) passes
// through the sum, divide, prepare, multiply and write states in turn; the result then
// waits in the done state while the previous result still blocks the output register. The
// very first frame after reset skips the filter, going from the sum state to the write state.
// A new word is taken while the previous result still waits in the output register. Channels
// beyond the fifth are ignored and result fields of unused channels are zero.
`include "assert_macros.svh"

module trajectory_kalman_smoother
   import tks_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int CHANNELS  = 5
) (
   input logic         clock,
   input logic         reset,
   tks_stream_if.sink   req_bus,
   tks_stream_if.source rsp_bus,
   tks_stream_if.sink   csr_bus
);

   localparam int NUM_ACT = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;
   localparam int CH_W    = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;
   localparam int GAIN_W  = FRAC_BITS + 1;
   localparam int BIT_W   = $clog2(FRAC_BITS + 1);
   localparam int P_W     = WORD_W;
   localparam int DEN_W   = P_W + 2;
   localparam int REM_W   = DEN_W + 1;
   localparam int DIFF_W  = WORD_W + 1;
   localparam int ACCE_W  = SAT_W;
   localparam int ACCV_W  = P_W + 2;

   localparam logic [GAIN_W-1:0] ONE       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [WORD_W-1:0] VAR_RESET = WORD_W'(1) << FRAC_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_PREP  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic                     first_ff, first_in;
   logic [CFG_W-1:0]         q_noise_ff, q_noise_in;
   logic [CFG_W-1:0]         r_noise_ff, r_noise_in;

   logic signed [WORD_W-1:0] ts_ff [NUM_ACT];
   logic signed [WORD_W-1:0] ts_in [NUM_ACT];
   logic signed [WORD_W-1:0] est_ff [NUM_ACT];
   logic signed [WORD_W-1:0] est_in [NUM_ACT];
   logic [WORD_W-1:0]        ev_ff [NUM_ACT];
   logic [WORD_W-1:0]        ev_in [NUM_ACT];
   logic signed [WORD_W-1:0] dl_ff [NUM_ACT];
   logic signed [WORD_W-1:0] dl_in [NUM_ACT];
   logic signed [WORD_W-1:0] os_ff [NUM_ACT];
   logic signed [WORD_W-1:0] os_in [NUM_ACT];

   logic signed [WORD_W-1:0] sum_ff, sum_in;
   logic [P_W-1:0]           p_ff, p_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [GAIN_W-1:0]        quo_ff, quo_in;
   logic [GAIN_W-1:0]        g_ff, g_in;
   logic [GAIN_W-1:0]        h_ff, h_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [ACCE_W-1:0] acce_ff, acce_in;
   logic [ACCV_W-1:0]        accv_ff, accv_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   field_arr_type            req_fields;
   field_arr_type            rsp_fields;

   logic signed [SAT_W-1:0]  sum_wide;
   logic [P_W:0]             p_wide;
   logic                     div_ge;
   logic [REM_W-1:0]         rem_sub;
   logic [GAIN_W-1:0]        gain;
   logic                     bit_last;
   logic signed [ACCE_W-1:0] mul_e;
   logic [ACCV_W-1:0]        mul_v;
   logic signed [WORD_W-1:0] est_new;
   logic [WORD_W-1:0]        ev_new;
   logic signed [WORD_W-1:0] out_new;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.word  = rsp_word_ff;

   assign req_fields = to_fields(req_bus.word);
   assign bit_last   = (bit_ff == BIT_W'(FRAC_BITS));

   always_comb begin
      rsp_fields = '{default: '0};
      for (int c = 0; c < NUM_ACT; c++) begin
         rsp_fields[c] = os_ff[c];
      end
   end

   always_comb begin
      sum_wide = SAT_W'(ts_ff[0]) + SAT_W'(dl_ff[0]);
      p_wide   = {1'b0, ev_ff[0]} + (P_W + 1)'(q_noise_ff);
      div_ge   = (rem_ff >= {1'b0, den_ff});
      rem_sub  = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      gain     = (den_ff == '0) ? '0 : quo_ff;
      mul_e    = acce_ff + (g_ff[0] ? ACCE_W'(diff_ff) : '0);
      mul_v    = accv_ff + (h_ff[0] ? {2'b00, p_ff} : '0);
      est_new  = first_ff ? est_ff[0] : sat32(SAT_W'(est_ff[0]) + acce_ff);
      ev_new   = first_ff ? ev_ff[0] : accv_ff[WORD_W-1:0];
      out_new  = sat32(SAT_W'(dl_ff[0]) + SAT_W'(est_new) - SAT_W'(sum_ff));
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      bit_in       = bit_ff;
      first_in     = first_ff;
      q_noise_in   = q_noise_ff;
      r_noise_in   = r_noise_ff;
      ts_in        = ts_ff;
      est_in       = est_ff;
      ev_in        = ev_ff;
      dl_in        = dl_ff;
      os_in        = os_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      g_in         = g_ff;
      h_in         = h_ff;
      diff_in      = diff_ff;
      acce_in      = acce_ff;
      accv_in      = accv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.word.reg_index)
            CSR_PROCESS_NOISE:     q_noise_in = csr_bus.word.reg_data;
            CSR_MEASUREMENT_NOISE: r_noise_in = csr_bus.word.reg_data;
            default:               q_noise_in = q_noise_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               for (int c = 0; c < NUM_ACT; c++) begin
                  dl_in[c] = req_fields[c];
               end
               ch_in    = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sat32(sum_wide);
            p_in     = p_wide[P_W] ? '1 : p_wide[P_W-1:0];
            den_in   = DEN_W'(p_in) + DEN_W'(r_noise_ff);
            rem_in   = REM_W'(p_in);
            quo_in   = '0;
            bit_in   = '0;
            state_in = first_ff ? ST_WRITE : ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[GAIN_W-2:0], div_ge};
            rem_in = {rem_sub[REM_W-2:0], 1'b0};
            bit_in = bit_ff + BIT_W'(1);
            if (bit_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            g_in     = gain;
            h_in     = ONE - gain;
            diff_in  = DIFF_W'(sum_ff) - DIFF_W'(est_ff[0]);
            acce_in  = '0;
            accv_in  = '0;
            bit_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acce_in = bit_last ? mul_e : (mul_e >>> 1);
            accv_in = bit_last ? mul_v : (mul_v >> 1);
            g_in    = g_ff >> 1;
            h_in    = h_ff >> 1;
            bit_in  = bit_ff + BIT_W'(1);
            if (bit_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            for (int c = 0; c < NUM_ACT - 1; c++) begin
               ts_in[c]  = ts_ff[c+1];
               est_in[c] = est_ff[c+1];
               ev_in[c]  = ev_ff[c+1];
               dl_in[c]  = dl_ff[c+1];
               os_in[c]  = os_ff[c+1];
            end
            ts_in[NUM_ACT-1]  = sum_ff;
            est_in[NUM_ACT-1] = est_new;
            ev_in[NUM_ACT-1]  = ev_new;
            dl_in[NUM_ACT-1]  = dl_ff[0];
            os_in[NUM_ACT-1]  = out_new;
            if (ch_ff == CH_W'(NUM_ACT - 1)) begin
               first_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = ST_SUM;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = from_fields(rsp_fields);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         bit_ff       <= '0;
         first_ff     <= 1'b1;
         q_noise_ff   <= PROCESS_NOISE_RESET;
         r_noise_ff   <= MEASUREMENT_NOISE_RESET;
         ts_ff        <= '{default: '0};
         est_ff       <= '{default: '0};
         ev_ff        <= '{default: VAR_RESET};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         bit_ff       <= bit_in;
         first_ff     <= first_in;
         q_noise_ff   <= q_noise_in;
         r_noise_ff   <= r_noise_in;
         ts_ff        <= ts_in;
         est_ff       <= est_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff       <= dl_in;
      os_ff       <= os_in;
      sum_ff      <= sum_in;
      p_ff        <= p_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      g_ff        <= g_in;
      h_ff        <= h_in;
      diff_ff     <= diff_in;
      acce_ff     <= acce_in;
      accv_ff     <= accv_in;
      rsp_word_ff <= rsp_word_in;
   end

   `ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `ASSERT_SAME(a_bit_range, clock, reset, (state_ff == ST_DIV) || (state_ff == ST_MUL), bit_ff <= BIT_W'(FRAC_BITS))
   `ASSERT_SAME(a_gain_bound, clock, reset, (state_ff == ST_MUL) && (bit_ff == '0), (g_ff <= ONE) && (h_ff == ONE - g_ff))
   `ASSERT_SAME(a_var_shrinks, clock, reset, (state_ff == ST_WRITE) && !first_ff, accv_ff <= {2'b00, p_ff})

endmodule

// File: verif/trajectory_kalman_smoother_tb.sv
module trajectory_kalman_smoother_tb;
   import tks_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam longint unsigned ONE = 64'd1 << FRAC;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES = 200;
   localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;
   localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

   logic clock;
   logic reset = 1'b1;

   tks_stream_if #(.word_type(req_word_type)) req_if ();
   tks_stream_if #(.word_type(rsp_word_type)) rsp_if ();
   tks_stream_if #(.word_type(csr_word_type)) csr_if ();

   trajectory_kalman_smoother #(.FRAC_BITS(FRAC), .CHANNELS(NUM_FIELDS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Smoother state as the block should hold it.
   longint path_sum [NUM_FIELDS] = '{default: 0};
   longint path_est [NUM_FIELDS] = '{default: 0};
   longint unsigned path_var [NUM_FIELDS] = '{default: 64'd1 << FRAC};
   bit awaiting_first = 1'b1;
   longint unsigned q_noise = 64'(PROCESS_NOISE_RESET);
   longint unsigned r_noise = 64'(MEASUREMENT_NOISE_RESET);

   rsp_word_type smoothed_q [$];
   int error_count = 0;
   bit src_idle_en = 1'b0;
   bit snk_idle_en = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   string field_name [NUM_FIELDS] = '{"smooth_x", "smooth_y", "smooth_angle",
                                      "smooth_scale_x", "smooth_scale_y"};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_s32(input longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (x < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
      return x;
   endfunction

   function automatic rsp_word_type smooth_frame(input req_word_type frame);
      logic [WORD_W*NUM_FIELDS-1:0] in_bits;
      logic [WORD_W*NUM_FIELDS-1:0] out_bits;
      logic signed [WORD_W-1:0] lane;
      longint delta, sum_v, est_v;
      longint unsigned p, den, gain;
      in_bits = frame;
      out_bits = '0;
      for (int c = 0; c < NUM_FIELDS; c++) begin
         lane = in_bits[WORD_W*(NUM_FIELDS-c)-1 -: WORD_W];
         delta = longint'(lane);
         sum_v = clamp_s32(path_sum[c] + delta);
         est_v = path_est[c];
         path_sum[c] = sum_v;
         if (!awaiting_first) begin
            p = path_var[c] + q_noise;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            den = p + r_noise;
            gain = (den == 0) ? 64'd0 : (p << FRAC) / den;
            if (gain > ONE) gain = ONE;
            est_v = clamp_s32(est_v + ((longint'(gain) * (sum_v - est_v)) >>> FRAC));
            path_est[c] = est_v;
            path_var[c] = ((ONE - gain) * p) >> FRAC;
         end
         out_bits[WORD_W*(NUM_FIELDS-c)-1 -: WORD_W] = WORD_W'(clamp_s32(delta + est_v - sum_v));
      end
      awaiting_first = 1'b0;
      return out_bits;
   endfunction

   always @(posedge clock) begin
      if (!reset && csr_if.valid && csr_if.ready) begin
         case (csr_if.word.reg_index)
            CSR_PROCESS_NOISE:     q_noise = 64'(csr_if.word.reg_data);
            CSR_MEASUREMENT_NOISE: r_noise = 64'(csr_if.word.reg_data);
            default: ;
         endcase
      end
      if (!reset && req_if.valid && req_if.ready) begin
         smoothed_q.insert(smoothed_q.size(), smooth_frame(req_if.word));
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      logic [WORD_W*NUM_FIELDS-1:0] want_bits;
      logic [WORD_W*NUM_FIELDS-1:0] got_bits;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (smoothed_q.size() == 0) begin
            $error("result word with no expected word pending");
            error_count++;
         end else begin
            want = smoothed_q.pop_front();
            want_bits = want;
            got_bits = rsp_if.word;
            for (int f = 0; f < NUM_FIELDS; f++) begin
               if (got_bits[WORD_W*(NUM_FIELDS-f)-1 -: WORD_W] !==
                   want_bits[WORD_W*(NUM_FIELDS-f)-1 -: WORD_W]) begin
                  $error("%s: expected %0d, got %0d", field_name[f],
                         $signed(want_bits[WORD_W*(NUM_FIELDS-f)-1 -: WORD_W]),
                         $signed(got_bits[WORD_W*(NUM_FIELDS-f)-1 -: WORD_W]));
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0 && snk_idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_frame(input req_word_type frame);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word <= frame;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_uniform(input logic [WORD_W-1:0] v);
      req_word_type frame;
      frame = '{v, v, v, v, v};
      send_frame(frame);
   endtask

   // Holds the sender off until every expected word has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (smoothed_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_word_type cw;
      cw.reg_index = idx;
      cw.reg_data = data;
      csr_if.valid <= 1'b1;
      csr_if.word <= cw;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_noise(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r);
      drain_results();
      write_csr(CSR_PROCESS_NOISE, q);
      write_csr(CSR_MEASUREMENT_NOISE, r);
   endtask

   function automatic logic [WORD_W-1:0] motion_value();
      case ($urandom_range(0, 11))
         0:       return S32_MAX;
         1:       return S32_MIN;
         2, 3, 4: return $urandom();
         5:       return WORD_W'($urandom_range(0, 32)) - 32'd16;
         default: return WORD_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] noise_value();
      case ($urandom_range(0, 5))
         0:       return CFG_W'(1);
         1:       return CFG_MAX;
         2:       return 21'h10_0000;
         3:       return CFG_W'($urandom_range(1, 2048));
         default: return CFG_W'($urandom());
      endcase
   endfunction

   function automatic req_word_type random_frame();
      req_word_type frame;
      frame.delta_x = motion_value();
      frame.delta_y = motion_value();
      frame.delta_angle = motion_value();
      frame.scale_x = motion_value();
      frame.scale_y = motion_value();
      return frame;
   endfunction

   // The first word after reset skips the filter; the sums are then driven into both rails.
   task automatic test_first_frame_and_extremes();
      req_word_type frame;
      send_uniform(S32_MAX);
      send_uniform(S32_MAX);
      send_uniform(S32_MIN);
      send_uniform(S32_MIN);
      send_uniform(32'h0000_0000);
      send_uniform(32'h5555_5555);
      send_uniform(32'hAAAA_AAAA);
      frame = '{S32_MAX, S32_MIN, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF};
      send_frame(frame);
   endtask

   // The estimate is left far from a sum that jumps across the range, so the result clips.
   task automatic test_output_saturation();
      set_noise(PROCESS_NOISE_RESET, 21'd1);
      repeat (3) send_uniform(S32_MAX);
      set_noise(21'd1, CFG_MAX);
      repeat (2) send_uniform(S32_MIN);
      send_uniform(S32_MAX);
      set_noise(PROCESS_NOISE_RESET, 21'd1);
      repeat (3) send_uniform(S32_MIN);
      set_noise(21'd1, CFG_MAX);
      repeat (2) send_uniform(S32_MAX);
      send_uniform(S32_MIN);
   endtask

   // With both noise terms at zero the variance collapses and the gain divisor becomes zero.
   task automatic test_zero_denominator();
      set_noise(21'd0, 21'd0);
      repeat (4) send_frame(random_frame());
   endtask

   task automatic test_noise_sweep();
      logic [CFG_W-1:0] q_set [6] = '{21'd1, 21'h10_0000, CFG_MAX, 21'd1, CFG_MAX,
                                      PROCESS_NOISE_RESET};
      logic [CFG_W-1:0] r_set [6] = '{21'd1, 21'h10_0000, CFG_MAX, CFG_MAX, 21'd1,
                                      MEASUREMENT_NOISE_RESET};
      for (int s = 0; s < 6; s++) begin
         set_noise(q_set[s], r_set[s]);
         repeat (16) send_frame(random_frame());
      end
   endtask

   task automatic test_random_frames();
      for (int phase = 0; phase < 10; phase++) begin
         set_noise(noise_value(), noise_value());
         src_idle_en = (phase < 8) && (phase != 3);
         snk_idle_en = (phase < 8) && (phase != 5);
         repeat (125) send_frame(random_frame());
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.word = '0;
      csr_if.valid = 1'b0;
      csr_if.word = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      test_first_frame_and_extremes();
      test_output_saturation();
      test_zero_denominator();
      test_noise_sweep();
      test_random_frames();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (smoothed_q.size() != 0) begin
         $error("%0d expected words never arrived", smoothed_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
